// ===== hdl/btksi_pkg.sv =====
`default_nettype none

package btksi_pkg;

    // stream widths (tdata padded to whole bytes)
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 2;

    // request type codes on s_tuser
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_CLEAR  = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    // status codes on m_tuser
    localparam logic [1:0] STAT_IGNORED  = 2'd0;
    localparam logic [1:0] STAT_INSERTED = 2'd1;
    localparam logic [1:0] STAT_READ     = 2'd2;
    localparam logic [1:0] STAT_CLEARED  = 2'd3;

    // score of an empty slot
    localparam logic [31:0] EMPTY_SCORE = 32'd99999;

    // classified operation handed from front end to engine
    typedef enum logic [1:0] {
        OP_INSERT,
        OP_CLEAR,
        OP_READ,
        OP_IGNORE
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_CHECK,
        S_PRIME,
        S_WALK
    } eng_state_t;

    typedef struct packed {
        op_t         op;
        logic [1:0]  bank;
        logic [3:0]  rank;
        logic [15:0] player_id;
        logic [31:0] score;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  placed_rank;
        logic [15:0] out_id;
        logic [31:0] out_score;
    } res_t;

endpackage

`default_nettype wire

// ===== hdl/btksi_front.sv =====
`default_nettype none

module btksi_front #(
    parameter int BANK_COUNT = 3,
    parameter int LIST_DEPTH = 10
) (
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // bank[1:0], player_id[17:2], score[49:18], read_rank[53:50], zero pad
    input  wire logic [btksi_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type[1:0]
    input  wire logic [btksi_pkg::S_TUSER_W-1:0] s_tuser,
    input  wire logic                            q_full,
    output logic                                 q_push,
    output btksi_pkg::cmd_t                      q_cmd
);
    import btksi_pkg::*;

    logic [1:0]  req_type;
    logic [1:0]  bank;
    logic [3:0]  rank;
    logic        bank_ok;
    logic        rank_ok;

    // unpack the transaction
    assign req_type = s_tuser[1:0];
    assign bank     = s_tdata[1:0];
    assign rank     = s_tdata[53:50];

    assign bank_ok = {1'b0, bank} < 3'(BANK_COUNT);
    assign rank_ok = {1'b0, rank} < 5'(LIST_DEPTH);

    // classify the request so the engine only sees legal work
    always_comb begin
        q_cmd.bank      = bank;
        q_cmd.rank      = rank;
        q_cmd.player_id = s_tdata[17:2];
        q_cmd.score     = s_tdata[49:18];
        case (req_type)
            REQ_INSERT: q_cmd.op = bank_ok ? OP_INSERT : OP_IGNORE;
            REQ_CLEAR:  q_cmd.op = OP_CLEAR;
            REQ_READ:   q_cmd.op = (bank_ok && rank_ok) ? OP_READ : OP_IGNORE;
            default:    q_cmd.op = OP_IGNORE;
        endcase
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

endmodule

`default_nettype wire

// ===== hdl/btksi_queue.sv =====
`default_nettype none

module btksi_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire btksi_pkg::cmd_t push_cmd,
    input  wire logic            pop,
    output btksi_pkg::cmd_t      head_cmd,
    output logic                 full,
    output logic                 not_empty
);
    import btksi_pkg::*;

    // two-entry command queue
    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign head_cmd  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/btksi_engine.sv =====
`default_nettype none

module btksi_engine #(
    parameter int BANK_COUNT = 3,
    parameter int LIST_DEPTH = 10
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            q_valid,
    input  wire btksi_pkg::cmd_t q_cmd,
    output logic                 q_pop,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output btksi_pkg::res_t      m_res
);
    import btksi_pkg::*;

    localparam int TOTAL  = BANK_COUNT * LIST_DEPTH;
    localparam int ADDR_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int RANK_W = $clog2(LIST_DEPTH);
    localparam logic [RANK_W-1:0] LAST_RANK = RANK_W'(LIST_DEPTH - 1);

    eng_state_t        state_reg;
    eng_state_t        state_next;
    op_t               op_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [15:0]       id_reg;
    logic [31:0]       score_reg;
    logic [RANK_W-1:0] rd_rank_reg;
    logic [RANK_W-1:0] wk_rank_reg;
    logic [RANK_W-1:0] pos_reg;
    logic              placed_reg;
    logic [15:0]       carry_id_reg;
    logic [31:0]       carry_score_reg;
    logic              out_valid_reg;
    res_t              out_res_reg;

    // entry store with a valid bit per entry; invalid entries read as empty
    logic [15:0]       mem_id    [TOTAL];
    logic [31:0]       mem_score [TOTAL];
    logic [TOTAL-1:0]  valid_reg;
    logic [15:0]       rd_id_reg;
    logic [31:0]       rd_score_reg;
    logic              rd_vld_reg;

    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wk_addr;
    logic [15:0]       old_id;
    logic [31:0]       old_score;
    logic              wk_last;

    // control outputs of the sequencer
    logic              clear_all;
    logic              res_load;
    res_t              res_next;
    logic              wr_en;
    logic [15:0]       wr_id;
    logic [31:0]       wr_score;
    logic              place_now;

    assign rd_addr   = base_reg + ADDR_W'(rd_rank_reg);
    assign wk_addr   = base_reg + ADDR_W'(wk_rank_reg);
    assign old_id    = rd_vld_reg ? rd_id_reg : 16'd0;
    assign old_score = rd_vld_reg ? rd_score_reg : EMPTY_SCORE;
    assign wk_last   = wk_rank_reg == LAST_RANK;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (q_valid && !out_valid_reg &&
                    (q_cmd.op == OP_INSERT || q_cmd.op == OP_READ)) begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH: begin
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (op_reg == OP_INSERT && score_reg < old_score) begin
                    state_next = S_PRIME;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_PRIME: begin
                state_next = S_WALK;
            end
            S_WALK: begin
                if (wk_last) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        q_pop     = 1'b0;
        clear_all = 1'b0;
        res_load  = 1'b0;
        res_next  = '0;
        wr_en     = 1'b0;
        wr_id     = id_reg;
        wr_score  = score_reg;
        place_now = 1'b0;
        case (state_reg)
            S_IDLE: begin
                q_pop = q_valid && !out_valid_reg;
                if (q_pop && q_cmd.op == OP_IGNORE) begin
                    res_load        = 1'b1;
                    res_next.status = STAT_IGNORED;
                end else if (q_pop && q_cmd.op == OP_CLEAR) begin
                    clear_all       = 1'b1;
                    res_load        = 1'b1;
                    res_next.status = STAT_CLEARED;
                end
            end
            S_CHECK: begin
                if (op_reg == OP_READ) begin
                    res_load           = 1'b1;
                    res_next.status    = STAT_READ;
                    res_next.out_id    = old_id;
                    res_next.out_score = old_score;
                end else if (!(score_reg < old_score)) begin
                    // does not beat the last entry
                    res_load        = 1'b1;
                    res_next.status = STAT_IGNORED;
                end
            end
            S_WALK: begin
                // new entry lands at the first strictly worse slot, then
                // each later slot takes its predecessor
                if (!placed_reg && (old_score > score_reg || wk_last)) begin
                    wr_en     = 1'b1;
                    place_now = 1'b1;
                end else if (placed_reg) begin
                    wr_en    = 1'b1;
                    wr_id    = carry_id_reg;
                    wr_score = carry_score_reg;
                end
                if (wk_last) begin
                    res_load             = 1'b1;
                    res_next.status      = STAT_INSERTED;
                    res_next.placed_rank = place_now ? 4'(wk_rank_reg) : 4'(pos_reg);
                end
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            placed_reg    <= 1'b0;
            valid_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (res_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (q_pop) begin
                placed_reg <= 1'b0;
            end else if (place_now) begin
                placed_reg <= 1'b1;
            end
            if (clear_all) begin
                valid_reg <= '0;
            end else if (wr_en) begin
                valid_reg[wk_addr] <= 1'b1;
            end
        end
    end

    // request latch and walk counters
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            op_reg    <= q_cmd.op;
            base_reg  <= ADDR_W'(q_cmd.bank * LIST_DEPTH);
            id_reg    <= q_cmd.player_id;
            score_reg <= q_cmd.score;
            rd_rank_reg <= (q_cmd.op == OP_READ) ? RANK_W'(q_cmd.rank) : LAST_RANK;
        end else if (state_reg == S_CHECK) begin
            rd_rank_reg <= '0;
        end else if (state_reg == S_PRIME) begin
            rd_rank_reg <= RANK_W'(1);
            wk_rank_reg <= '0;
        end else if (state_reg == S_WALK) begin
            if (rd_rank_reg != LAST_RANK) begin
                rd_rank_reg <= rd_rank_reg + RANK_W'(1);
            end
            wk_rank_reg <= wk_rank_reg + RANK_W'(1);
        end
        if (place_now || (state_reg == S_WALK && placed_reg)) begin
            carry_id_reg    <= old_id;
            carry_score_reg <= old_score;
        end
        if (place_now) begin
            pos_reg <= wk_rank_reg;
        end
        if (res_load) begin
            out_res_reg <= res_next;
        end
    end

    // entry store: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_id[wk_addr]    <= wr_id;
            mem_score[wk_addr] <= wr_score;
        end
        rd_id_reg    <= mem_id[rd_addr];
        rd_score_reg <= mem_score[rd_addr];
        rd_vld_reg   <= valid_reg[rd_addr];
    end

    assign m_valid = out_valid_reg;
    assign m_res   = out_res_reg;

    // checks
    a_pop_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !out_valid_reg)
        else $error("request taken while result register busy");

    a_load_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> !out_valid_reg)
        else $error("result overwritten before transfer");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_cmd.op == OP_CLEAR) |=> (valid_reg == '0))
        else $error("clear left valid entries");

    a_write_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == S_WALK && $past(state_reg) != S_IDLE))
        else $error("entry store written outside the insert walk");

endmodule

`default_nettype wire

// ===== hdl/banked_top_k_sorted_insert_unit.sv =====
`default_nettype none

// Banked top-K list keeper. BANK_COUNT lists of LIST_DEPTH entries each,
// every entry an id and a score kept in ascending score order.
// Slave channel s_*: one request per transaction, type on s_tuser
// (insert, clear, read). Master channel m_*: exactly one result per request,
// status on m_tuser, placed rank, id and score on m_tdata.
// A front end classifies requests into a two-entry queue; the engine runs
// one request at a time against a one-read one-write entry store.
// Engine steps per request: an ignored or clear request is answered as it is
// popped, a read fetches and checks its slot, and an insert checks the last slot,
// then walks one slot per cycle through the store port.
// Requests are not overlapped in the engine, and it takes the next one only
// after the result register has emptied.
// Reset empties all lists (id 0, score 99999) at once through per-entry
// valid bits; no sweep is needed. A clear request does the same.
// When m_tready is low the result waits in the output register; the queue
// still takes up to two more requests before s_tready drops.
module banked_top_k_sorted_insert_unit #(
    parameter int BANK_COUNT = 3,
    parameter int LIST_DEPTH = 10
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // bank[1:0], player_id[17:2], score[49:18], read_rank[53:50], zero pad
    input  wire logic [btksi_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type[1:0]
    input  wire logic [btksi_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // placed_rank[3:0], out_id[19:4], out_score[51:20], zero pad
    output logic [btksi_pkg::M_TDATA_W-1:0]      m_tdata,
    // status[1:0]
    output logic [btksi_pkg::M_TUSER_W-1:0]      m_tuser
);
    import btksi_pkg::*;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_not_empty;
    cmd_t push_cmd;
    cmd_t head_cmd;
    res_t res;

    btksi_front #(
        .BANK_COUNT (BANK_COUNT),
        .LIST_DEPTH (LIST_DEPTH)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    btksi_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .pop       (q_pop),
        .head_cmd  (head_cmd),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    btksi_engine #(
        .BANK_COUNT (BANK_COUNT),
        .LIST_DEPTH (LIST_DEPTH)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_not_empty),
        .q_cmd   (head_cmd),
        .q_pop   (q_pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_res   (res)
    );

    // pack the result transaction
    assign m_tdata = {4'd0, res.out_score, res.out_id, res.placed_rank};
    assign m_tuser = res.status;

endmodule

`default_nettype wire
